// ----- hdl/voice_activity_segmenter_core_defines.svh -----
// assertion macros for the voice activity segmenter rtl
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef VOICE_ACTIVITY_SEGMENTER_CORE_DEFINES_SVH
`define VOICE_ACTIVITY_SEGMENTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VAS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`define VAS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);
`else
`define VAS_ASSERT_IMPL(lbl, ante, cons, msg)
`define VAS_ASSERT_NEXT(lbl, ante, cons, msg)
`define VAS_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// ----- hdl/vas_pkg.sv -----
// shared types, widths and codes for the voice activity segmenter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vas_pkg;
	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 16;
	localparam int PEAK_W    = 15;
	localparam int CNT_W     = 24;
	localparam int PREROLL_W = 13;
	localparam int EVENT_W   = 3;
	localparam int CAUSE_W   = 2;
	localparam int THR_W     = 16;

	localparam int DEFAULT_PREROLL_SAMPLES = 8000;

	// register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SILENCE   = 2'd1;
	localparam logic [1:0] REG_MAX_SPEECH = 2'd2;

	localparam logic [THR_W-1:0] RST_THRESHOLD  = 16'd655;
	localparam logic [CNT_W-1:0] RST_SILENCE    = 24'd16000;
	localparam logic [CNT_W-1:0] RST_MAX_SPEECH = 24'd160000;

	// decision codes
	localparam logic [EVENT_W-1:0] EV_IDLE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_FORWARD = 3'd2;
	localparam logic [EVENT_W-1:0] EV_SLICED  = 3'd3;
	localparam logic [EVENT_W-1:0] EV_DROPPED = 3'd4;

	localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_SILENCE = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_MAXLEN  = 2'd2;

	typedef struct packed {
		logic [THR_W-1:0] voice_threshold;
		logic [CNT_W-1:0] silence_trigger;
		logic [CNT_W-1:0] max_speech;
	} vas_cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       end_of_chunk;
		logic                       no_data;
		logic [LEN_W-1:0]           elapsed_samples;
	} vas_item_t;

	typedef struct packed {
		logic [CAUSE_W-1:0]   slice_cause;
		logic [PREROLL_W-1:0] preroll_flush_count;
		logic                 voice_present;
		logic [PEAK_W-1:0]    peak_level;
		logic [EVENT_W-1:0]   event_res;
	} vas_result_t;
endpackage
`default_nettype wire

// ----- hdl/vas_regs.sv -----
// apb configuration registers of the voice activity segmenter
// depends on vas_pkg
`timescale 1ns / 1ps
`default_nettype none
module vas_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready,
	output vas_pkg::vas_cfg_t   cfg
);
	import vas_pkg::*;

	logic [THR_W-1:0] threshold_q;
	logic [CNT_W-1:0] silence_q;
	logic [CNT_W-1:0] max_speech_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= RST_THRESHOLD;
			silence_q    <= RST_SILENCE;
			max_speech_q <= RST_MAX_SPEECH;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_THRESHOLD:  threshold_q  <= pwdata[THR_W-1:0];
				REG_SILENCE:    silence_q    <= pwdata[CNT_W-1:0];
				REG_MAX_SPEECH: max_speech_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_THRESHOLD:  prdata = {16'd0, threshold_q};
			REG_SILENCE:    prdata = {8'd0, silence_q};
			REG_MAX_SPEECH: prdata = {8'd0, max_speech_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.voice_threshold = threshold_q;
	assign cfg.silence_trigger = silence_q;
	assign cfg.max_speech      = max_speech_q;
endmodule
`default_nettype wire

// ----- hdl/vas_engine.sv -----
// chunk peak tracking and idle/speaking/processing decision state
// depends on vas_pkg and voice_activity_segmenter_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "voice_activity_segmenter_core_defines.svh"
module vas_engine #(
	parameter int PREROLL_SAMPLES = vas_pkg::DEFAULT_PREROLL_SAMPLES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  vas_pkg::vas_item_t    item,
	input  vas_pkg::vas_cfg_t     cfg,
	output logic                  res_valid,
	output vas_pkg::vas_result_t  res
);
	import vas_pkg::*;

	localparam int PREROLL_MAX = (1 << PREROLL_W) - 1;
	localparam int PREROLL_CAP = (PREROLL_SAMPLES > PREROLL_MAX) ? PREROLL_MAX
		: PREROLL_SAMPLES;

	localparam logic [1:0] ST_IDLE       = 2'd0;
	localparam logic [1:0] ST_SPEAKING   = 2'd1;
	localparam logic [1:0] ST_PROCESSING = 2'd2;

	logic [1:0]           state_q, state_d;
	logic [CNT_W-1:0]     silence_q, silence_d;
	logic [CNT_W-1:0]     speech_q, speech_d;
	logic [PREROLL_W-1:0] preroll_q, preroll_d;
	logic [PEAK_W-1:0]    peak_q, peak_d;
	logic [LEN_W-1:0]     len_q, len_d;

	logic [PEAK_W-1:0]    mag;
	logic [PEAK_W-1:0]    peak_new;
	logic [LEN_W-1:0]     len_new;
	logic                 decide;
	logic                 is_data;
	logic [LEN_W-1:0]     delta;
	logic [PEAK_W-1:0]    dec_peak;
	logic                 voice;
	logic [CNT_W:0]       speech_sum, silence_sum;
	logic [CNT_W-1:0]     speech_sat, silence_sat;
	logic [PREROLL_W+3:0] preroll_sum;

	always_comb begin
		if (!item.sample[SAMPLE_W-1])
			mag = item.sample[PEAK_W-1:0];
		else if (item.sample[PEAK_W-1:0] == '0)
			mag = PEAK_W'(PREROLL_MAX) | '1; // most negative sample saturates
		else
			mag = PEAK_W'(-item.sample);
	end

	assign peak_new = (mag > peak_q) ? mag : peak_q;
	assign len_new  = (len_q == '1) ? len_q : len_q + 1'b1;

	assign is_data  = !item.no_data;
	assign decide   = item.no_data ? (item.elapsed_samples != '0) : item.end_of_chunk;
	assign delta    = is_data ? len_new : item.elapsed_samples;
	assign dec_peak = is_data ? peak_new : '0;
	assign voice    = is_data && ({1'b0, dec_peak} >= cfg.voice_threshold);

	assign speech_sum  = {1'b0, speech_q} + (CNT_W+1)'(delta);
	assign silence_sum = {1'b0, silence_q} + (CNT_W+1)'(delta);
	assign speech_sat  = speech_sum[CNT_W] ? '1 : speech_sum[CNT_W-1:0];
	assign silence_sat = silence_sum[CNT_W] ? '1 : silence_sum[CNT_W-1:0];
	assign preroll_sum = (PREROLL_W+4)'(preroll_q) + (PREROLL_W+4)'(delta);

	always_comb begin
		state_d   = state_q;
		silence_d = silence_q;
		speech_d  = speech_q;
		preroll_d = preroll_q;
		peak_d    = peak_q;
		len_d     = len_q;
		res       = '0;

		// partial data chunk survives an empty-chunk item
		if (is_data) begin
			peak_d = item.end_of_chunk ? '0 : peak_new;
			len_d  = item.end_of_chunk ? '0 : len_new;
		end

		res.peak_level    = dec_peak;
		res.voice_present = voice;

		if (decide) begin
			unique case (state_q)
				ST_SPEAKING: begin
					speech_d  = speech_sat;
					silence_d = voice ? '0 : silence_sat;
					if (silence_d >= cfg.silence_trigger)
						res.slice_cause = CAUSE_SILENCE;
					else if (speech_d >= cfg.max_speech)
						res.slice_cause = CAUSE_MAXLEN;
					if (res.slice_cause != CAUSE_NONE) begin
						state_d       = ST_PROCESSING;
						res.event_res = EV_SLICED;
					end else begin
						res.event_res = EV_FORWARD;
					end
				end
				ST_PROCESSING: begin
					state_d       = ST_IDLE;
					preroll_d     = '0;
					res.event_res = EV_DROPPED;
				end
				default: begin
					// idle, and the unused code behaves as idle
					if (voice) begin
						state_d   = ST_SPEAKING;
						silence_d = '0;
						speech_d  = '0;
						preroll_d = '0;
						res.preroll_flush_count = preroll_q;
						res.event_res = EV_START;
					end else begin
						if (is_data)
							preroll_d = (preroll_sum > (PREROLL_W+4)'(PREROLL_CAP))
								? PREROLL_W'(PREROLL_CAP) : preroll_sum[PREROLL_W-1:0];
						res.event_res = EV_IDLE;
					end
				end
			endcase
		end
	end

	assign res_valid = decide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			silence_q <= '0;
			speech_q  <= '0;
			preroll_q <= '0;
			peak_q    <= '0;
			len_q     <= '0;
		end else if (fire) begin
			state_q   <= state_d;
			silence_q <= silence_d;
			speech_q  <= speech_d;
			preroll_q <= preroll_d;
			peak_q    <= peak_d;
			len_q     <= len_d;
		end
	end

	`VAS_ASSERT_IMPL(a_slice_has_cause, fire && res_valid && res.event_res == EV_SLICED, res.slice_cause != CAUSE_NONE, "sliced decision without cause")
	`VAS_ASSERT_IMPL(a_flush_on_start_only, fire && res_valid && res.event_res != EV_START, res.preroll_flush_count == '0, "pre-roll flushed outside speech start")
	`VAS_ASSERT_ALWAYS(a_preroll_capped, preroll_q <= PREROLL_W'(PREROLL_CAP), "pre-roll count above cap")
	`VAS_ASSERT_NEXT(a_start_enters_speaking, fire && res_valid && res.event_res == EV_START, state_q == ST_SPEAKING && silence_q == '0 && speech_q == '0, "speech start did not enter speaking")
endmodule
`default_nettype wire

// ----- hdl/voice_activity_segmenter_core.sv -----
// top level of the voice activity segmenter: input register, decision engine,
// result register and apb configuration; depends on vas_pkg, vas_regs, vas_engine
`timescale 1ns / 1ps
`default_nettype none
// Peak-threshold voice activity detector. Samples stream in on the s_ side, one
// per transaction; s_tlast closes a chunk and s_tuser marks an empty chunk whose
// silence length rides in the elapsed field. At each chunk end (if empty, only
// with nonzero elapsed) one decision goes out on the m_ side (idle, speech
// start with pre-roll flush count, forwarded, forwarded and sliced with the
// cause, or dropped); other transactions give no output. An item waits in the
// input register; combinational logic before the result register decides it.
// The engine makes a single state update per item, so one item is taken every
// cycle while the result register is empty or being drained. The user must
// write configuration over apb only while the block is idle (unenforced).
module voice_activity_segmenter_core #(
	parameter int PREROLL_SAMPLES = vas_pkg::DEFAULT_PREROLL_SAMPLES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // sample[15:0], elapsed_samples[31:16]
	input  wire logic        s_tlast,   // end_of_chunk
	input  wire logic        s_tuser,   // no_data
	// decision stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// event_res[2:0], peak_level[17:3], voice_present[18],
	// preroll_flush_count[31:19], slice_cause[33:32], zero fill above
	output logic [39:0]      m_tdata,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import vas_pkg::*;

	vas_cfg_t    cfg;
	vas_item_t   item_s1;
	logic        valid_s1;
	logic        fire;
	logic        res_valid;
	vas_result_t res;
	vas_result_t res_q;
	logic        m_valid_q;

	vas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the engine consumes the registered item when the result slot is free or being drained
	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.sample          <= s_tdata[15:0];
			item_s1.elapsed_samples <= s_tdata[31:16];
			item_s1.end_of_chunk    <= s_tlast;
			item_s1.no_data         <= s_tuser;
		end
	end

	vas_engine #(
		.PREROLL_SAMPLES (PREROLL_SAMPLES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: loads on a chunk-end decision, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q};
endmodule
`default_nettype wire
